// ===== sv/pdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdpc_pkg
// Shared constants, register codes and stage types of the PD position
// controller.
// ----------------------------------------------------------------------------
package pdpc_pkg;

    localparam int POSITION_WIDTH     = 24;
    localparam int GAIN_FRACTION_BITS = 8;

    localparam int GAIN_W      = 16;
    localparam int DRIVE_MAG_W = 7;
    localparam int DRIVE_W     = DRIVE_MAG_W + 1;
    localparam int BAND_W      = 16;

    localparam int E_W    = POSITION_WIDTH + 2;
    localparam int DE_W   = E_W + 1;
    localparam int PE_W   = E_W + GAIN_W + 1;
    localparam int PD_W   = DE_W + GAIN_W + 1;
    localparam int ACC_W  = PD_W + 1;
    localparam int SHIFT  = GAIN_FRACTION_BITS + 1;
    localparam int SH_W   = ACC_W - SHIFT;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = POSITION_WIDTH;

    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DRIVE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_BELOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_TO    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DONE_BAND   = 3'd6;

    localparam logic [GAIN_W-1:0]      RST_P_GAIN      = 16'd51;
    localparam logic [GAIN_W-1:0]      RST_D_GAIN      = 16'd128;
    localparam logic [DRIVE_MAG_W-1:0] RST_MAX_DRIVE   = 7'd127;
    localparam logic [DRIVE_MAG_W-1:0] RST_BOOST_BELOW = 7'd20;
    localparam logic [DRIVE_MAG_W-1:0] RST_BOOST_TO    = 7'd25;
    localparam logic [BAND_W-1:0]      RST_DONE_BAND   = 16'd10;

    typedef struct packed {
        logic signed [E_W-1:0]  e2;
        logic signed [DE_W-1:0] de;
    } t_err;

    typedef struct packed {
        logic signed [PE_W-1:0] p_term;
        logic signed [PD_W-1:0] d_term;
        logic                   done;
    } t_prod;

endpackage

// ===== sv/pdpc_error.sv =====
// ----------------------------------------------------------------------------
// pdpc_error
// Error stage: doubled error against the setpoint, its change since the
// previous item, and the previous-error register.
// ----------------------------------------------------------------------------
module pdpc_error (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_load,
    input  logic signed [pdpc_pkg::POSITION_WIDTH-1:0] i_setpoint,
    input  logic signed [pdpc_pkg::POSITION_WIDTH-1:0] i_left,
    input  logic signed [pdpc_pkg::POSITION_WIDTH-1:0] i_right,
    output pdpc_pkg::t_err                             o_err
);

    logic signed [pdpc_pkg::E_W-1:0] r_last_error;
    logic signed [pdpc_pkg::E_W-1:0] n_e2;
    pdpc_pkg::t_err                  r_err;
    pdpc_pkg::t_err                  n_err;

    always_comb begin
        n_e2 = pdpc_pkg::E_W'(i_setpoint) + pdpc_pkg::E_W'(i_setpoint)
             - pdpc_pkg::E_W'(i_left) - pdpc_pkg::E_W'(i_right);
        n_err.e2 = n_e2;
        n_err.de = pdpc_pkg::DE_W'(n_e2) - pdpc_pkg::DE_W'(r_last_error);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
        end else if (i_load) begin
            r_last_error <= n_e2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_err <= n_err;
        end
    end

    assign o_err = r_err;

endmodule

// ===== sv/pdpc_gain.sv =====
// ----------------------------------------------------------------------------
// pdpc_gain
// Gain stage: proportional and derivative products, done-band compare.
// ----------------------------------------------------------------------------
module pdpc_gain (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  pdpc_pkg::t_err                    i_err,
    input  logic [pdpc_pkg::GAIN_W-1:0]       i_p_gain,
    input  logic [pdpc_pkg::GAIN_W-1:0]       i_d_gain,
    input  logic [pdpc_pkg::BAND_W-1:0]       i_done_band,
    output pdpc_pkg::t_prod                   o_prod
);

    logic [pdpc_pkg::E_W-1:0] w_e_mag;
    pdpc_pkg::t_prod          n_prod;
    pdpc_pkg::t_prod          r_prod;

    always_comb begin
        w_e_mag       = i_err.e2[pdpc_pkg::E_W-1] ? pdpc_pkg::E_W'(-i_err.e2)
                                                  : pdpc_pkg::E_W'(i_err.e2);
        n_prod.p_term = i_err.e2 * $signed({1'b0, i_p_gain});
        n_prod.d_term = i_err.de * $signed({1'b0, i_d_gain});
        n_prod.done   = (w_e_mag <= pdpc_pkg::E_W'({i_done_band, 1'b0}));
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== sv/pdpc_shape.sv =====
// ----------------------------------------------------------------------------
// pdpc_shape
// Output stage: sum, scale toward zero, clamp or boost, result register.
// ----------------------------------------------------------------------------
module pdpc_shape (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  pdpc_pkg::t_prod                     i_prod,
    input  logic [pdpc_pkg::DRIVE_MAG_W-1:0]    i_max_drive,
    input  logic [pdpc_pkg::DRIVE_MAG_W-1:0]    i_boost_below,
    input  logic [pdpc_pkg::DRIVE_MAG_W-1:0]    i_boost_to,
    output logic signed [pdpc_pkg::DRIVE_W-1:0] o_drive,
    output logic                                o_done
);

    logic signed [pdpc_pkg::ACC_W-1:0]   w_acc;
    logic [pdpc_pkg::ACC_W-1:0]          w_acc_mag;
    logic [pdpc_pkg::SH_W-1:0]           w_mag_sh;
    logic [pdpc_pkg::DRIVE_MAG_W-1:0]    w_mag;
    logic signed [pdpc_pkg::DRIVE_W-1:0] n_drive;
    logic signed [pdpc_pkg::DRIVE_W-1:0] r_drive;
    logic                                r_done;

    always_comb begin
        w_acc     = pdpc_pkg::ACC_W'(i_prod.p_term) + pdpc_pkg::ACC_W'(i_prod.d_term);
        w_acc_mag = w_acc[pdpc_pkg::ACC_W-1] ? pdpc_pkg::ACC_W'(-w_acc)
                                             : pdpc_pkg::ACC_W'(w_acc);
        w_mag_sh  = pdpc_pkg::SH_W'(w_acc_mag >> pdpc_pkg::SHIFT);
        if (w_mag_sh > pdpc_pkg::SH_W'(i_max_drive)) begin
            w_mag = i_max_drive;
        end else if (w_mag_sh != '0 && w_mag_sh < pdpc_pkg::SH_W'(i_boost_below)) begin
            w_mag = i_boost_to;
        end else begin
            w_mag = w_mag_sh[pdpc_pkg::DRIVE_MAG_W-1:0];
        end
        n_drive = w_acc[pdpc_pkg::ACC_W-1] ? -$signed({1'b0, w_mag})
                                           : $signed({1'b0, w_mag});
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_drive <= n_drive;
            r_done  <= i_prod.done;
        end
    end

    assign o_drive = r_drive;
    assign o_done  = r_done;

endmodule

// ===== sv/pd_position_controller_top.sv =====
// ----------------------------------------------------------------------------
// pd_position_controller_top
// PD position controller with drive clamp and minimum-drive boost.
// Input, error, gain and output registers lie between input accept and result
// valid. Throughput: one item per cycle, stalls only on output.
// Reset (synchronous, active low): pipeline empty, previous error zero,
// configuration registers at their defaults.
// ----------------------------------------------------------------------------
module pd_position_controller_top (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  logic signed [pdpc_pkg::POSITION_WIDTH-1:0] i_left_position,
    input  logic signed [pdpc_pkg::POSITION_WIDTH-1:0] i_right_position,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic signed [pdpc_pkg::DRIVE_W-1:0]        o_drive,
    output logic                                       o_done_res,
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [pdpc_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [pdpc_pkg::CFG_DATA_W-1:0]            i_cfg_data
);

    logic signed [pdpc_pkg::POSITION_WIDTH-1:0] r_setpoint;
    logic [pdpc_pkg::GAIN_W-1:0]                r_p_gain;
    logic [pdpc_pkg::GAIN_W-1:0]                r_d_gain;
    logic [pdpc_pkg::DRIVE_MAG_W-1:0]           r_max_drive;
    logic [pdpc_pkg::DRIVE_MAG_W-1:0]           r_boost_below;
    logic [pdpc_pkg::DRIVE_MAG_W-1:0]           r_boost_to;
    logic [pdpc_pkg::BAND_W-1:0]                r_done_band;

    logic signed [pdpc_pkg::POSITION_WIDTH-1:0] r_left;
    logic signed [pdpc_pkg::POSITION_WIDTH-1:0] r_right;
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_ld1, w_ld2, w_ld3, w_ld4;

    pdpc_pkg::t_err  w_err;
    pdpc_pkg::t_prod w_prod;

    logic [pdpc_pkg::DRIVE_MAG_W:0] w_out_mag;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint    <= '0;
            r_p_gain      <= pdpc_pkg::RST_P_GAIN;
            r_d_gain      <= pdpc_pkg::RST_D_GAIN;
            r_max_drive   <= pdpc_pkg::RST_MAX_DRIVE;
            r_boost_below <= pdpc_pkg::RST_BOOST_BELOW;
            r_boost_to    <= pdpc_pkg::RST_BOOST_TO;
            r_done_band   <= pdpc_pkg::RST_DONE_BAND;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pdpc_pkg::CFG_SETPOINT: begin
                    r_setpoint <= $signed(i_cfg_data[pdpc_pkg::POSITION_WIDTH-1:0]);
                end
                pdpc_pkg::CFG_P_GAIN: begin
                    r_p_gain <= i_cfg_data[pdpc_pkg::GAIN_W-1:0];
                end
                pdpc_pkg::CFG_D_GAIN: begin
                    r_d_gain <= i_cfg_data[pdpc_pkg::GAIN_W-1:0];
                end
                pdpc_pkg::CFG_MAX_DRIVE: begin
                    r_max_drive <= i_cfg_data[pdpc_pkg::DRIVE_MAG_W-1:0];
                end
                pdpc_pkg::CFG_BOOST_BELOW: begin
                    r_boost_below <= i_cfg_data[pdpc_pkg::DRIVE_MAG_W-1:0];
                end
                pdpc_pkg::CFG_BOOST_TO: begin
                    r_boost_to <= i_cfg_data[pdpc_pkg::DRIVE_MAG_W-1:0];
                end
                pdpc_pkg::CFG_DONE_BAND: begin
                    r_done_band <= i_cfg_data[pdpc_pkg::BAND_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // stage advance, back to front
    assign w_ld4      = r_v3 && (!r_v4 || i_out_ready);
    assign w_ld3      = r_v2 && (!r_v3 || w_ld4);
    assign w_ld2      = r_v1 && (!r_v2 || w_ld3);
    assign o_in_ready = !r_v1 || w_ld2;
    assign w_ld1      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= w_ld1 || (r_v1 && !w_ld2);
            r_v2 <= w_ld2 || (r_v2 && !w_ld3);
            r_v3 <= w_ld3 || (r_v3 && !w_ld4);
            r_v4 <= w_ld4 || (r_v4 && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_left  <= i_left_position;
            r_right <= i_right_position;
        end
    end

    pdpc_error u_error (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_ld2),
        .i_setpoint (r_setpoint),
        .i_left     (r_left),
        .i_right    (r_right),
        .o_err      (w_err)
    );

    pdpc_gain u_gain (
        .i_clk       (i_clk),
        .i_load      (w_ld3),
        .i_err       (w_err),
        .i_p_gain    (r_p_gain),
        .i_d_gain    (r_d_gain),
        .i_done_band (r_done_band),
        .o_prod      (w_prod)
    );

    pdpc_shape u_shape (
        .i_clk         (i_clk),
        .i_load        (w_ld4),
        .i_prod        (w_prod),
        .i_max_drive   (r_max_drive),
        .i_boost_below (r_boost_below),
        .i_boost_to    (r_boost_to),
        .o_drive       (o_drive),
        .o_done        (o_done_res)
    );

    assign o_out_valid = r_v4;

    assign w_out_mag = o_drive[pdpc_pkg::DRIVE_W-1] ? pdpc_pkg::DRIVE_W'(-o_drive)
                                                    : pdpc_pkg::DRIVE_W'(o_drive);

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> o_in_ready)
        else $error("input stage empty but not ready");

    a_drive_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (w_out_mag <= {1'b0, r_max_drive}) ||
                        (w_out_mag == {1'b0, r_boost_to}))
        else $error("drive neither clamped nor boosted value");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && i_out_ready && !r_v3) |=> !r_v4)
        else $error("result repeated after delivery");

    a_no_overtake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_ld3) |=> r_v2)
        else $error("error stage item lost while stalled");

endmodule
